// ===== design/kst_pkg.sv =====
// ---------------------------------------------------------------------------
// kst_pkg: shared constants for the keypad scanner and tone player
// Register indexes, reset values and the per-key tone half-period table.
// ---------------------------------------------------------------------------
package kst_pkg;

    localparam int HALF_PERIOD_BITS_DEF = 13;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    localparam int SCAN_BITS     = 16;
    localparam int DEBOUNCE_BITS = 20;
    localparam int NOTE_BITS     = 24;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCAN_INTERVAL  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TICKS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOTE_TICKS     = 2'd2;

    localparam logic [SCAN_BITS-1:0]     SCAN_INTERVAL_RST  = 16'd500;
    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_TICKS_RST = 20'd20000;
    localparam logic [NOTE_BITS-1:0]     NOTE_TICKS_RST     = 24'd200000;

    // Half period in ticks for keys 1..16: (46083 / f) * 10, all below 2048
    localparam logic [15:0] KEY_HALF_PERIOD [16] = '{
        16'd880, 16'd930, 16'd1040, 16'd1170,
        16'd580, 16'd660, 16'd690,  16'd780,
        16'd390, 16'd440, 16'd460,  16'd520,
        16'd260, 16'd290, 16'd330,  16'd340
    };

endpackage

// ===== design/keypad_scan_tone_player.sv =====
// ---------------------------------------------------------------------------
// keypad_scan_tone_player: 4x4 matrix keypad scanner with square-wave buzzer
// One input item is one timer tick with the column readback; each tick yields
// one result item with the row drive, buzzer pin, latched key and play flag.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+--------------------------------------
//  s_      | in        | s_tvalid/tready  | tdata[3:0] column_lines
//  m_      | out       | m_tvalid/tready  | tdata[3:0] row_drive, [4] tone_out,
//          |           |                  | [9:5] key_code, [10] playing
//  cfg_    | in        | cfg_we           | cfg_index, cfg_wdata (no read-back)
//
// Cycles: one tick per clock unless stalled; state update and result are one
// pass of logic from the accepted item into the state and output registers.
// Throughput is one item per cycle with m_tready high; m_tvalid is registered.
// Reset (aresetn low, synchronous) returns to idle with the pin high and no key.
// Stalls: a held result blocks s_tready only while m_tready is low.
// ---------------------------------------------------------------------------
module keypad_scan_tone_player #(
    parameter int HALF_PERIOD_BITS = kst_pkg::HALF_PERIOD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [kst_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [kst_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // tick items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [3:0] column_lines
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata    // [3:0] row_drive, [4] tone_out,
                                                           // [9:5] key_code, [10] playing
);
    import kst_pkg::*;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_PRESENCE = 6'b000010,
        PH_DEBOUNCE = 6'b000100,
        PH_RECHECK  = 6'b001000,
        PH_ROWS     = 6'b010000,
        PH_PLAY     = 6'b100000
    } phase_t;

    localparam int HPB = HALF_PERIOD_BITS;

    // configuration
    logic [SCAN_BITS-1:0]     scan_interval_reg;
    logic [DEBOUNCE_BITS-1:0] debounce_ticks_reg;
    logic [NOTE_BITS-1:0]     note_ticks_reg;

    // scan and tone state
    phase_t                   phase_reg, phase_next;
    logic [SCAN_BITS-1:0]     scan_counter_reg, scan_counter_next;
    logic [DEBOUNCE_BITS-1:0] debounce_counter_reg, debounce_counter_next;
    logic [1:0]               row_index_reg, row_index_next;
    logic [4:0]               key_latched_reg, key_latched_next;
    logic [HPB-1:0]           note_half_period_reg, note_half_period_next;
    logic [HPB-1:0]           tone_counter_reg, tone_counter_next;
    logic [NOTE_BITS-1:0]     note_counter_reg, note_counter_next;
    logic                     tone_level_reg, tone_level_next;

    // output stage
    logic                     m_tvalid_reg;
    logic [15:0]              m_tdata_reg;
    logic [15:0]              m_tdata_next;

    logic                     s_accept;
    logic [3:0]               cols;
    logic [4:0]               row_key;
    logic                     row_hit;
    logic [4:0]               key_scan;
    logic [SCAN_BITS-1:0]     scan_inc;
    logic [HPB-1:0]           tone_inc;
    logic [NOTE_BITS-1:0]     note_inc;
    logic [3:0]               row_drive_next;
    logic [3:0]               key_slot;

    // Take a new tick whenever the output register is free or being emptied.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cols = s_tdata[3:0];

    // Highest pressed column of the driven row wins.
    always_comb begin
        row_key = 5'd0;
        row_hit = 1'b0;
        for (int c = 0; c < 4; c++) begin
            if (!cols[c]) begin
                row_key = {1'b0, row_index_reg, 2'(c)} + 5'd1;
                row_hit = 1'b1;
            end
        end
    end

    assign key_scan = row_hit ? row_key : key_latched_reg;
    assign key_slot = 4'(key_scan - 5'd1);

    assign scan_inc = scan_counter_reg + 1'b1;
    assign tone_inc = tone_counter_reg + 1'b1;
    assign note_inc = note_counter_reg + 1'b1;

    // Next state for one tick.
    always_comb begin
        phase_next            = phase_reg;
        scan_counter_next     = scan_counter_reg;
        debounce_counter_next = debounce_counter_reg;
        row_index_next        = row_index_reg;
        key_latched_next      = key_latched_reg;
        note_half_period_next = note_half_period_reg;
        tone_counter_next     = tone_counter_reg;
        note_counter_next     = note_counter_reg;
        tone_level_next       = tone_level_reg;

        unique case (phase_reg)
            PH_PRESENCE: begin
                if (cols != 4'hF) begin
                    phase_next            = PH_DEBOUNCE;
                    debounce_counter_next = '0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DEBOUNCE: begin
                if (debounce_counter_reg >= debounce_ticks_reg) begin
                    phase_next = PH_RECHECK;
                end else begin
                    debounce_counter_next = debounce_counter_reg + 1'b1;
                end
            end
            PH_RECHECK: begin
                if (cols != 4'hF) begin
                    phase_next     = PH_ROWS;
                    row_index_next = 2'd0;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_ROWS: begin
                key_latched_next = key_scan;
                if (row_index_reg == 2'd3) begin
                    row_index_next = 2'd0;
                    // start the note on the winning key, else drop back to idle
                    if (key_scan >= 5'd1 && key_scan <= 5'd16) begin
                        note_half_period_next = KEY_HALF_PERIOD[key_slot][HPB-1:0];
                        tone_counter_next     = '0;
                        note_counter_next     = '0;
                        tone_level_next       = 1'b1;
                        phase_next            = PH_PLAY;
                    end else begin
                        phase_next = PH_IDLE;
                    end
                end else begin
                    row_index_next = row_index_reg + 1'b1;
                end
            end
            PH_PLAY: begin
                // toggle the pin each half period
                if (tone_inc >= note_half_period_reg) begin
                    tone_counter_next = '0;
                    tone_level_next   = !tone_level_reg;
                end else begin
                    tone_counter_next = tone_inc;
                end
                note_counter_next = note_inc;
                // end of note: silence the pin, clear the key, resume scanning
                if (note_inc >= note_ticks_reg) begin
                    tone_level_next   = 1'b1;
                    key_latched_next  = 5'd0;
                    tone_counter_next = '0;
                    note_counter_next = '0;
                    scan_counter_next = '0;
                    phase_next        = PH_IDLE;
                end
            end
            default: begin
                // idle, and any stray code: count toward the next presence check
                phase_next        = PH_IDLE;
                scan_counter_next = scan_inc;
                if (scan_inc >= scan_interval_reg) begin
                    scan_counter_next = '0;
                    phase_next        = PH_PRESENCE;
                end
            end
        endcase
    end

    // Rows follow the phase the tick leaves behind.
    always_comb begin
        unique case (phase_next) inside
            PH_PRESENCE, PH_DEBOUNCE, PH_RECHECK: row_drive_next = 4'h0;
            PH_ROWS:                              row_drive_next = ~(4'b0001 << row_index_next);
            default:                              row_drive_next = 4'hF;
        endcase
    end

    assign m_tdata_next = {5'd0, (phase_next == PH_PLAY), key_latched_next,
                           tone_level_next, row_drive_next};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_interval_reg  <= SCAN_INTERVAL_RST;
            debounce_ticks_reg <= DEBOUNCE_TICKS_RST;
            note_ticks_reg     <= NOTE_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SCAN_INTERVAL:  scan_interval_reg  <= cfg_wdata[SCAN_BITS-1:0];
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata[DEBOUNCE_BITS-1:0];
                REG_NOTE_TICKS:     note_ticks_reg     <= cfg_wdata[NOTE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // state, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= PH_IDLE;
            scan_counter_reg     <= '0;
            debounce_counter_reg <= '0;
            row_index_reg        <= '0;
            key_latched_reg      <= '0;
            note_half_period_reg <= '0;
            tone_counter_reg     <= '0;
            note_counter_reg     <= '0;
            tone_level_reg       <= 1'b1;
        end else if (s_accept) begin
            phase_reg            <= phase_next;
            scan_counter_reg     <= scan_counter_next;
            debounce_counter_reg <= debounce_counter_next;
            row_index_reg        <= row_index_next;
            key_latched_reg      <= key_latched_next;
            note_half_period_reg <= note_half_period_next;
            tone_counter_reg     <= tone_counter_next;
            note_counter_reg     <= note_counter_next;
            tone_level_reg       <= tone_level_next;
        end
    end

    // output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // assertions
    a_silent_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[10]) |-> m_tdata[4])
        else $error("tone pin low while no note plays");

    a_play_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[9:5] >= 5'd1 && m_tdata[9:5] <= 5'd16))
        else $error("note playing without a valid key");

    a_play_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10]) |-> (m_tdata[3:0] == 4'hF))
        else $error("rows driven during a note");

    a_tone_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PLAY) |-> (tone_counter_reg <= note_half_period_reg))
        else $error("tone counter past half period");

    a_stall_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("item accepted over a stalled result");

endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for the keypad scanner and tone player
// A keypad model answers the row drive with column readback, one tick per
// item; a scoreboard predicts every result and compares it field by field.
// ---------------------------------------------------------------------------
module tb;

    import kst_pkg::*;

    localparam int HP_BITS = HALF_PERIOD_BITS_DEF;

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

    // Tone frequencies in Hz for keys 1..16
    localparam int KEY_FREQ_HZ [16] = '{
        523, 494, 440, 392, 784, 698, 659, 587,
        1174, 1046, 987, 880, 1760, 1567, 1396, 1318
    };

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_PRESENCE = 6'b000010,
        ST_DEBOUNCE = 6'b000100,
        ST_RECHECK  = 6'b001000,
        ST_ROWS     = 6'b010000,
        ST_PLAY     = 6'b100000
    } scan_state_t;

    // One result item as it sits in m_tdata[10:0]
    typedef struct packed {
        logic       playing;
        logic [4:0] key;
        logic       tone;
        logic [3:0] rows;
    } tick_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: tick-by-tick model of the scanner plus the queue of
    // results it owes.
    // -----------------------------------------------------------------------
    class tone_scoreboard;
        logic [SCAN_BITS-1:0]     scan_gap;
        logic [DEBOUNCE_BITS-1:0] settle_ticks;
        logic [NOTE_BITS-1:0]     note_len;

        scan_state_t              state;
        logic [SCAN_BITS-1:0]     interval_count;
        logic [DEBOUNCE_BITS-1:0] settle_count;
        logic [1:0]               row_sel;
        logic [4:0]               key_held;
        logic [HP_BITS-1:0]       half_period;
        logic [HP_BITS-1:0]       tone_count;
        logic [NOTE_BITS-1:0]     note_count;
        logic                     tone_pin;

        tick_result_t             owed_q[$];
        int                       errors;

        function new();
            scan_gap       = SCAN_INTERVAL_RST;
            settle_ticks   = DEBOUNCE_TICKS_RST;
            note_len       = NOTE_TICKS_RST;
            state          = ST_IDLE;
            interval_count = '0;
            settle_count   = '0;
            row_sel        = '0;
            key_held       = '0;
            half_period    = '0;
            tone_count     = '0;
            note_count     = '0;
            tone_pin       = 1'b1;
            errors         = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_SCAN_INTERVAL:  scan_gap     = val[SCAN_BITS-1:0];
                REG_DEBOUNCE_TICKS: settle_ticks = val[DEBOUNCE_BITS-1:0];
                REG_NOTE_TICKS:     note_len     = val[NOTE_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] row_drive();
            if (state == ST_PRESENCE || state == ST_DEBOUNCE || state == ST_RECHECK)
                return 4'h0;
            if (state == ST_ROWS)
                return 4'hF & ~(4'b0001 << row_sel);
            return 4'hF;
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        // Advance one tick on the column readback and queue the result it owes
        function void note_input(logic [3:0] cols);
            tick_result_t r;
            case (state)
                ST_PRESENCE: begin
                    if (cols != 4'hF) begin
                        state        = ST_DEBOUNCE;
                        settle_count = '0;
                    end else begin
                        state = ST_IDLE;
                    end
                end
                ST_DEBOUNCE: begin
                    if (settle_count >= settle_ticks)
                        state = ST_RECHECK;
                    else
                        settle_count = settle_count + 1'b1;
                end
                ST_RECHECK: begin
                    if (cols != 4'hF) begin
                        state   = ST_ROWS;
                        row_sel = '0;
                    end else begin
                        state = ST_IDLE;
                    end
                end
                ST_ROWS: begin
                    // later columns overwrite earlier ones: highest key wins
                    for (int c = 0; c < 4; c++)
                        if (!cols[c])
                            key_held = 5'(row_sel * 4 + c + 1);
                    if (row_sel == 2'd3) begin
                        row_sel = '0;
                        if (key_held != 0) begin
                            half_period = HP_BITS'((46083 / KEY_FREQ_HZ[key_held - 1]) * 10);
                            tone_count  = '0;
                            note_count  = '0;
                            tone_pin    = 1'b1;
                            state       = ST_PLAY;
                        end else begin
                            state = ST_IDLE;
                        end
                    end else begin
                        row_sel = row_sel + 1'b1;
                    end
                end
                ST_PLAY: begin
                    tone_count = tone_count + 1'b1;
                    if (tone_count >= half_period) begin
                        tone_count = '0;
                        tone_pin   = ~tone_pin;
                    end
                    note_count = note_count + 1'b1;
                    if (note_count >= note_len) begin
                        tone_pin       = 1'b1;
                        key_held       = '0;
                        tone_count     = '0;
                        note_count     = '0;
                        interval_count = '0;
                        state          = ST_IDLE;
                    end
                end
                default: begin
                    state          = ST_IDLE;
                    interval_count = interval_count + 1'b1;
                    if (interval_count >= scan_gap) begin
                        interval_count = '0;
                        state          = ST_PRESENCE;
                    end
                end
            endcase
            r.rows    = row_drive();
            r.tone    = tone_pin;
            r.key     = key_held;
            r.playing = (state == ST_PLAY);
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] tdata);
            tick_result_t want;
            tick_result_t got;
            got = tdata[10:0];
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("row_drive", want.rows, got.rows);
            compare_field("tone_out", want.tone, got.tone);
            compare_field("key_code", want.key, got.key);
            compare_field("playing", want.playing, got.playing);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and DUT
    // -----------------------------------------------------------------------
    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = 8'h0F;   // [3:0] column_lines
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;             // [3:0] row_drive, [4] tone_out,
                                                    // [9:5] key_code, [10] playing

    tone_scoreboard sb;

    // Keypad and pacing controls shared by the driving processes
    logic [15:0]  keys_down   = 16'h0000;  // bit r*4+c set: key in row r, column c held
    bit           keys_wander = 1'b0;      // let the keypad change and add noise
    bit           gaps_on     = 1'b0;      // sender idles in bursts
    bit           sink_idles  = 1'b0;      // receiver idles in bursts
    int           hold_cycles = 0;         // long receiver hold-off, counted by the sink
    logic [3:0]   forced_cols[$];          // column values sent as given

    initial begin
        forever #5 aclk = ~aclk;
    end

    keypad_scan_tone_player #(
        .HALF_PERIOD_BITS(HP_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Column readback of a 4x4 keypad: a column reads low when a held key
    // sits on a row that is driven low.
    function automatic logic [3:0] keypad_columns(logic [3:0] rows, logic [15:0] down);
        logic [3:0] cols;
        cols = 4'hF;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (!rows[r] && down[r*4+c])
                    cols[c] = 1'b0;
        return cols;
    endfunction

    // Offer count tick items. Columns answer the row drive that the block
    // shows after the last accepted item, so the keypad looks real to it.
    task automatic send_ticks(input int count);
        logic [3:0] cols;
        for (int n = 0; n < count; n++) begin
            if (gaps_on && $urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            if (forced_cols.size() != 0) begin
                cols = forced_cols.pop_front();
            end else begin
                // now and then press, release or mash keys
                if (keys_wander && $urandom_range(0, 29) == 0) begin
                    case ($urandom_range(0, 9)) inside
                        [0:2]:    keys_down = 16'h0000;
                        [3:6]:    keys_down = 16'h0001 << $urandom_range(0, 15);
                        default:  keys_down = 16'($urandom);
                    endcase
                end
                cols = keypad_columns(sb.row_drive(), keys_down);
                // contact noise breaks some sequences
                if (keys_wander && $urandom_range(0, 11) == 0)
                    cols = 4'($urandom);
            end
            s_tdata  <= {4'h0, cols};
            s_tvalid <= 1'b1;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            sb.note_input(cols);
        end
    endtask

    // Stop offering and hold until every owed result is in, plus a margin
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write all three registers back to back; junk adds a write to the
    // unused index first.
    task automatic write_config(input logic [CFG_DATA_BITS-1:0] scan,
                                input logic [CFG_DATA_BITS-1:0] settle,
                                input logic [CFG_DATA_BITS-1:0] note,
                                input bit junk);
        logic [CFG_INDEX_BITS-1:0] idx [4];
        logic [CFG_DATA_BITS-1:0]  val [4];
        idx = '{REG_UNUSED, REG_SCAN_INTERVAL, REG_DEBOUNCE_TICKS, REG_NOTE_TICKS};
        val = '{CFG_DATA_BITS'($urandom), scan, settle, note};
        for (int i = (junk ? 0 : 1); i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result sink: check every accepted result, then pick next m_tready
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int idle_left;
        idle_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if (hold_cycles > 0) begin
                // long hold-off: let the block back up and stall its input
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                m_tready <= 1'b0;
            end else if (sink_idles && $urandom_range(0, 9) == 0) begin
                idle_left = $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_BITS-1:0] scan_v;
        logic [CFG_DATA_BITS-1:0] settle_v;
        logic [CFG_DATA_BITS-1:0] note_v;
        int                       count;

        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: idle counting only, columns at both extremes
        forced_cols = '{4'h0, 4'hF};
        send_ticks(2);

        // Zero interval, zero debounce, zero note length, with a stray write
        // to the unused index; then walk whole scans by hand
        drain_results();
        write_config(24'd0, 24'd0, 24'd0, 1'b1);
        keys_down = 16'h8000;           // last key alone
        send_ticks(9);
        keys_down = 16'hFFFF;           // every key: the highest must win
        send_ticks(9);
        keys_down = 16'h0001;           // first key alone
        send_ticks(9);

        // Random part: each phase drains, reprograms and runs the keypad
        keys_wander = 1'b1;
        for (int p = 0; p < 10; p++) begin
            count = 120;
            case (p)
                0: begin
                    // lowest legal settings
                    scan_v = 24'd1; settle_v = 24'd0; note_v = 24'd1;
                end
                1: begin
                    // bits above the scan and debounce register widths must be dropped
                    scan_v = 24'hAB0002; settle_v = 24'hF00001; note_v = 24'd5;
                end
                3: begin
                    // highest settings: nothing moves on but the counters
                    scan_v = 24'd65535; settle_v = 24'd1048575; note_v = 24'd16777215;
                    count = 60;
                end
                4: begin
                    // a presence check follows every idle tick, but debounce never ends
                    scan_v = 24'd0; settle_v = 24'd1048575; note_v = 24'd16777215;
                    count = 60;
                end
                5: begin
                    // notes long enough for the pin to toggle
                    scan_v = 24'd0; settle_v = 24'd0; note_v = 24'd700;
                    count = 400;
                end
                default: begin
                    scan_v   = CFG_DATA_BITS'($urandom_range(0, 6));
                    settle_v = CFG_DATA_BITS'($urandom_range(0, 4));
                    note_v   = $urandom_range(0, 1) ? CFG_DATA_BITS'($urandom_range(0, 24))
                                                    : CFG_DATA_BITS'($urandom_range(260, 600));
                end
            endcase
            drain_results();
            write_config(scan_v, settle_v, note_v, p == 7);
            gaps_on    = ($urandom_range(0, 4) != 0);
            sink_idles = ($urandom_range(0, 4) != 0);
            if (p == 2)
                hold_cycles = 90;
            send_ticks(count);
        end

        // Closing stretch at full rate on both sides
        drain_results();
        write_config(CFG_DATA_BITS'($urandom_range(0, 6)), CFG_DATA_BITS'($urandom_range(0, 4)),
                     CFG_DATA_BITS'($urandom_range(0, 24)), 1'b0);
        gaps_on    = 1'b0;
        sink_idles = 1'b0;
        send_ticks(100);

        drain_results();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner
    initial begin : watchdog
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
